>>> rtl/cleb_pkg.sv
// shared types and constants of the cursor line edit buffer
// no dependencies; imported by every module of the block except the text ram
package cleb_pkg;

  // default line size, two bytes of which are never used for text
  localparam int unsigned LINE_BYTES_DEF = 256;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef enum logic [3:0] {
    ACT_CLEAR      = 4'd0,
    ACT_INSERT     = 4'd1,
    ACT_DEL_BACK   = 4'd2,
    ACT_DEL_FWD    = 4'd3,
    ACT_LEFT       = 4'd4,
    ACT_RIGHT      = 4'd5,
    ACT_HOME       = 4'd6,
    ACT_END        = 4'd7,
    ACT_KILL_END   = 4'd8,
    ACT_KILL_START = 4'd9,
    ACT_KILL_WORD  = 4'd10,
    ACT_READ       = 4'd11
  } action_e;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] char_in;
    logic [7:0] position;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] length_out;
    logic [7:0] cursor_out;
    logic [7:0] char_out;
  } res_t;

endpackage

>>> rtl/cleb_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module cleb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 254
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/cleb_ctrl.sv
// command sequencer: length and cursor registers, copy engine and word scan
// depends on cleb_pkg; drives the text ram through its ports
module cleb_ctrl #(
  parameter int unsigned LineBytes = cleb_pkg::LINE_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cleb_pkg::cmd_t                   in_data_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output cleb_pkg::res_t                   res_o,
  output logic                             mem_we_o,
  output logic [$clog2(LineBytes-2)-1:0]   mem_waddr_o,
  output logic [7:0]                       mem_wdata_o,
  output logic [$clog2(LineBytes-2)-1:0]   mem_raddr_o,
  input  logic [7:0]                       mem_rdata_i
);
  import cleb_pkg::*;

  localparam int unsigned MaxC = LineBytes - 2;
  localparam int unsigned AW   = $clog2(MaxC);
  localparam int unsigned LW   = $clog2(MaxC + 1);
  localparam int unsigned CmpW = (LW > 8) ? LW : 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_SCAN,
    ST_RDWAIT,
    ST_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] src_q, src_d;
  logic [LW-1:0] rem_q, rem_d;
  logic [LW-1:0] gap_q, gap_d;
  logic [LW-1:0] raddr_q, raddr_d;
  logic [LW-1:0] start_q, start_d;
  logic          up_q, up_d;
  logic          ins_q, ins_d;
  logic          rv_q, rv_d;
  logic          word_q, word_d;
  logic [7:0]    ch_q, ch_d;
  logic          acc_q, acc_d;
  logic [7:0]    chout_q, chout_d;

  logic          do_cut;
  logic [LW-1:0] cut_from, cut_to, start_n, waddr;
  logic [AW-1:0] raddr;
  logic [CmpW-1:0] pos_ext, len_ext;

  assign pos_ext = CmpW'(in_data_i.position);
  assign len_ext = CmpW'(len_q);
  assign start_n = start_q - LW'(1);

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    cur_d    = cur_q;
    src_d    = src_q;
    rem_d    = rem_q;
    gap_d    = gap_q;
    raddr_d  = raddr_q;
    start_d  = start_q;
    up_d     = up_q;
    ins_d    = ins_q;
    rv_d     = rv_q;
    word_d   = word_q;
    ch_d     = ch_q;
    acc_d    = acc_q;
    chout_d  = chout_q;
    do_cut   = 1'b0;
    cut_from = '0;
    cut_to   = '0;
    mem_we_o = 1'b0;
    waddr    = '0;
    mem_wdata_o = mem_rdata_i;
    raddr    = src_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          acc_d   = 1'b1;
          chout_d = '0;
          state_d = ST_DONE;
          case (in_data_i.action)
            ACT_CLEAR: begin
              len_d = '0;
              cur_d = '0;
            end
            ACT_INSERT: begin
              if (len_q >= LW'(MaxC)) begin
                acc_d = 1'b0;
              end else begin
                // shift the tail right from the last byte down to the cursor
                src_d   = len_q - LW'(1);
                rem_d   = len_q - cur_q;
                up_d    = 1'b0;
                ins_d   = 1'b1;
                rv_d    = 1'b0;
                ch_d    = in_data_i.char_in;
                state_d = ST_COPY;
              end
            end
            ACT_DEL_BACK: begin
              if (cur_q != '0) begin
                do_cut   = 1'b1;
                cut_from = cur_q - LW'(1);
                cut_to   = cur_q;
                cur_d    = cur_q - LW'(1);
              end
            end
            ACT_DEL_FWD: begin
              if (cur_q < len_q) begin
                do_cut   = 1'b1;
                cut_from = cur_q;
                cut_to   = cur_q + LW'(1);
              end
            end
            ACT_LEFT: begin
              if (cur_q != '0) begin
                cur_d = cur_q - LW'(1);
              end
            end
            ACT_RIGHT: begin
              if (cur_q < len_q) begin
                cur_d = cur_q + LW'(1);
              end
            end
            ACT_HOME: begin
              cur_d = '0;
            end
            ACT_END: begin
              cur_d = len_q;
            end
            ACT_KILL_END: begin
              len_d = cur_q;
            end
            ACT_KILL_START: begin
              if (cur_q != '0) begin
                do_cut   = 1'b1;
                cut_from = '0;
                cut_to   = cur_q;
                cur_d    = '0;
              end
            end
            ACT_KILL_WORD: begin
              if (cur_q != '0) begin
                raddr   = AW'(cur_q - LW'(1));
                raddr_d = cur_q - LW'(1);
                start_d = cur_q;
                word_d  = 1'b0;
                state_d = ST_SCAN;
              end
            end
            ACT_READ: begin
              if (pos_ext < len_ext) begin
                raddr   = pos_ext[AW-1:0];
                state_d = ST_RDWAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_COPY: begin
        // write back the byte read last cycle, issue the next read
        if (rv_q) begin
          mem_we_o = 1'b1;
          waddr    = up_q ? (raddr_q - gap_q) : (raddr_q + LW'(1));
        end
        if (rem_q != '0) begin
          raddr   = src_q[AW-1:0];
          raddr_d = src_q;
          rv_d    = 1'b1;
          src_d   = up_q ? (src_q + LW'(1)) : (src_q - LW'(1));
          rem_d   = rem_q - LW'(1);
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            if (ins_q) begin
              mem_we_o    = 1'b1;
              waddr       = cur_q;
              mem_wdata_o = ch_q;
              cur_d       = cur_q + LW'(1);
              len_d       = len_q + LW'(1);
            end
            state_d = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        // byte before start arrives; trailing spaces first, then the word
        if (!word_q || (mem_rdata_i != SPACE_BYTE)) begin
          if (mem_rdata_i != SPACE_BYTE) begin
            word_d = 1'b1;
          end
          start_d = start_n;
          if (start_n != '0) begin
            raddr   = AW'(raddr_q - LW'(1));
            raddr_d = raddr_q - LW'(1);
          end else begin
            do_cut   = 1'b1;
            cut_from = '0;
            cut_to   = cur_q;
            cur_d    = '0;
          end
        end else begin
          do_cut   = 1'b1;
          cut_from = start_q;
          cut_to   = cur_q;
          cur_d    = start_q;
        end
      end

      ST_RDWAIT: begin
        chout_d = mem_rdata_i;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // remove [cut_from, cut_to) by copying the tail down over the gap
    if (do_cut) begin
      gap_d   = cut_to - cut_from;
      src_d   = cut_to;
      rem_d   = len_q - cut_to;
      up_d    = 1'b1;
      ins_d   = 1'b0;
      rv_d    = 1'b0;
      len_d   = len_q - (cut_to - cut_from);
      state_d = ST_COPY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      cur_q   <= '0;
      src_q   <= '0;
      rem_q   <= '0;
      gap_q   <= '0;
      raddr_q <= '0;
      start_q <= '0;
      up_q    <= 1'b0;
      ins_q   <= 1'b0;
      rv_q    <= 1'b0;
      word_q  <= 1'b0;
      ch_q    <= '0;
      acc_q   <= 1'b1;
      chout_q <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      src_q   <= src_d;
      rem_q   <= rem_d;
      gap_q   <= gap_d;
      raddr_q <= raddr_d;
      start_q <= start_d;
      up_q    <= up_d;
      ins_q   <= ins_d;
      rv_q    <= rv_d;
      word_q  <= word_d;
      ch_q    <= ch_d;
      acc_q   <= acc_d;
      chout_q <= chout_d;
    end
  end

  assign mem_waddr_o = waddr[AW-1:0];
  assign mem_raddr_o = raddr;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_o            = '0;
    res_o.accepted   = acc_q;
    res_o.length_out = 8'(len_q);
    res_o.cursor_out = 8'(cur_q);
    res_o.char_out   = chout_q;
  end

endmodule

>>> rtl/cursor_line_edit_buffer_core.sv
// path: cursor moves, clear and kill to end go from idle straight to the done state; read passes
//   through a read wait state; edits run the copy engine, and kill word scans back before it
// throughput: one transaction at a time; the text ram moves one byte per cycle through its
//   single read port while a command holds the sequencer
// reset: length and cursor clear to zero, no transaction pending; the text ram is not
//   cleared, only bytes below the length are ever read
module cursor_line_edit_buffer_core #(
  parameter int unsigned LineBytes = cleb_pkg::LINE_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cleb_pkg::cmd_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cleb_pkg::res_t out_data_o
);
  import cleb_pkg::*;

  localparam int unsigned AW = $clog2(LineBytes - 2);

  // sequencer to result stage
  logic   res_valid;
  logic   res_ready;
  res_t   res;

  // text ram port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // output register
  logic out_valid_q, out_valid_d;
  res_t out_data_q, out_data_d;

  cleb_ctrl #(
    .LineBytes (LineBytes)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // one byte per entry, LineBytes - 2 entries of text
  cleb_ram #(
    .Width (8),
    .Depth (LineBytes - 2)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result stage takes a new result when empty or being drained this cycle,
  // so the sequencer can go back to idle while a result waits downstream
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> bench/cleb_checker.sv
`timescale 1ns / 1ps
// scoreboard for the cursor line edit buffer: watches both channels, keeps its own line and cursor
// depends on cleb_pkg; hands failure and outstanding counts to the bench top
module cleb_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  cleb_pkg::cmd_t in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  cleb_pkg::res_t out_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import cleb_pkg::*;

  localparam int unsigned TextBytes = LINE_BYTES_DEF - 2;
  localparam int unsigned ReportMax = 10;

  logic [7:0]  line_text [TextBytes];
  int unsigned line_len;
  int unsigned line_cur;
  res_t        expected_q [$];
  res_t        want;

  // drop bytes [from, to) and close the gap
  function automatic void cut_text(int unsigned from, int unsigned to);
    int unsigned gap;
    int unsigned i;
    gap = to - from;
    for (i = to; i < line_len; i++) line_text[i - gap] = line_text[i];
    line_len -= gap;
  endfunction

  // apply one command to the shadow line and return the result it should produce
  function automatic res_t edit_line(cmd_t c);
    res_t        r;
    int unsigned start;
    int unsigned i;
    r          = '0;
    r.accepted = 1'b1;
    case (c.action)
      ACT_CLEAR: begin
        line_len = 0;
        line_cur = 0;
      end
      ACT_INSERT: begin
        if (line_len >= TextBytes) begin
          r.accepted = 1'b0;
        end else begin
          for (i = line_len; i > line_cur; i--) line_text[i] = line_text[i - 1];
          line_text[line_cur] = c.char_in;
          line_cur++;
          line_len++;
        end
      end
      ACT_DEL_BACK: begin
        if (line_cur > 0) begin
          cut_text(line_cur - 1, line_cur);
          line_cur--;
        end
      end
      ACT_DEL_FWD: begin
        if (line_cur < line_len) cut_text(line_cur, line_cur + 1);
      end
      ACT_LEFT: begin
        if (line_cur > 0) line_cur--;
      end
      ACT_RIGHT: begin
        if (line_cur < line_len) line_cur++;
      end
      ACT_HOME: line_cur = 0;
      ACT_END: line_cur = line_len;
      ACT_KILL_END: line_len = line_cur;
      ACT_KILL_START: begin
        if (line_cur > 0) begin
          cut_text(0, line_cur);
          line_cur = 0;
        end
      end
      ACT_KILL_WORD: begin
        // trailing spaces first, then the word in front of them
        start = line_cur;
        while (start > 0 && line_text[start - 1] == SPACE_BYTE) start--;
        while (start > 0 && line_text[start - 1] != SPACE_BYTE) start--;
        if (start != line_cur) begin
          cut_text(start, line_cur);
          line_cur = start;
        end
      end
      ACT_READ: begin
        if (c.position < line_len) r.char_out = line_text[c.position];
      end
      default: ;
    endcase
    r.length_out = 8'(line_len);
    r.cursor_out = 8'(line_cur);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      line_len = 0;
      line_cur = 0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      // results first: a result leaving at this edge belongs to an earlier command
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax)
            $display("%0t: result with no command outstanding: acc %0d len %0d cur %0d char %02h",
                     $time, out_data_i.accepted, out_data_i.length_out,
                     out_data_i.cursor_out, out_data_i.char_out);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.accepted !== want.accepted ||
              out_data_i.length_out !== want.length_out ||
              out_data_i.cursor_out !== want.cursor_out ||
              out_data_i.char_out !== want.char_out) begin
            fail_count_o++;
            if (fail_count_o <= ReportMax)
              $display("%0t: wrong result: expected acc %0d len %0d cur %0d char %02h, got acc %0d len %0d cur %0d char %02h",
                       $time, want.accepted, want.length_out, want.cursor_out, want.char_out,
                       out_data_i.accepted, out_data_i.length_out, out_data_i.cursor_out,
                       out_data_i.char_out);
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(edit_line(in_data_i));
      pending_o = expected_q.size();
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// bench top for the cursor line edit buffer: drives commands and result backpressure,
// gives the verdict
// depends on cleb_pkg, cursor_line_edit_buffer_core and cleb_checker
module tb_top;
  import cleb_pkg::*;

  // codes outside the defined set, which must act as no-ops
  localparam logic [3:0]  ACT_UNUSED_LO = 4'd12;
  localparam logic [3:0]  ACT_UNUSED_HI = 4'd15;
  localparam int unsigned TextBytes     = LINE_BYTES_DEF - 2;
  localparam int unsigned TotalItems    = 1050;
  localparam int unsigned HoldOffCycles = 1500;
  // worst command walks the whole line once, plus margin
  localparam int unsigned DrainCycles   = 600;
  localparam int unsigned LimitNs       = 50_000_000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  cmd_t in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  res_t out_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_count;
  bit          no_idle;
  // set by the stimulus, consumed by the receiver process
  bit          hold_off_req;

  always #5 clk = ~clk;

  cursor_line_edit_buffer_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  cleb_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 200);
  endfunction

  function automatic cmd_t make_cmd(logic [3:0] act, logic [7:0] ch, logic [7:0] pos);
    cmd_t c;
    c.action   = act;
    c.char_in  = ch;
    c.position = pos;
    return c;
  endfunction

  // plenty of spaces so that kill word finds words to remove
  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 9) < 3) return SPACE_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // reads mostly land inside short lines
  function automatic logic [7:0] rand_pos();
    if ($urandom_range(0, 99) < 65) return 8'($urandom_range(0, 40));
    return 8'($urandom_range(0, TextBytes - 1));
  endfunction

  function automatic cmd_t rand_move();
    case ($urandom_range(0, 4))
      0:       return make_cmd(ACT_LEFT, rand_char(), rand_pos());
      1:       return make_cmd(ACT_RIGHT, rand_char(), rand_pos());
      2:       return make_cmd(ACT_HOME, rand_char(), rand_pos());
      3:       return make_cmd(ACT_END, rand_char(), rand_pos());
      default: return make_cmd(ACT_READ, rand_char(), 8'($urandom_range(0, TextBytes - 1)));
    endcase
  endfunction

  // weighted toward inserts so lines grow; unused fields carry random values too
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned r;
    r = $urandom_range(0, 99);
    c = make_cmd(ACT_INSERT, rand_char(), rand_pos());
    if (r < 38)      c.action = ACT_INSERT;
    else if (r < 47) c.action = ACT_READ;
    else if (r < 53) c.action = ACT_DEL_BACK;
    else if (r < 57) c.action = ACT_DEL_FWD;
    else if (r < 65) c.action = ACT_LEFT;
    else if (r < 71) c.action = ACT_RIGHT;
    else if (r < 74) c.action = ACT_HOME;
    else if (r < 78) c.action = ACT_END;
    else if (r < 81) c.action = ACT_KILL_END;
    else if (r < 84) c.action = ACT_KILL_START;
    else if (r < 93) c.action = ACT_KILL_WORD;
    else if (r < 95) c.action = ACT_CLEAR;
    else if (r < 96) c.action = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    else             c.action = ACT_READ;
    return c;
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic push_cmd(input cmd_t c);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= c;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sent_count++;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  task automatic edit_burst(int unsigned n);
    no_idle = ($urandom_range(0, 3) == 0);
    repeat (n) push_cmd(rand_cmd());
    no_idle = 1'b0;
  endtask

  // build a full line from empty, with cursor jumps so inserts also land mid-line,
  // then keep inserting so the full-line refusal is hit several times
  task automatic fill_line();
    int unsigned k;
    push_cmd(make_cmd(ACT_CLEAR, rand_char(), rand_pos()));
    for (k = 0; k < TextBytes + 6; k++) begin
      if ($urandom_range(0, 9) == 0) push_cmd(rand_move());
      push_cmd(make_cmd(ACT_INSERT, rand_char(), rand_pos()));
    end
    push_cmd(make_cmd(ACT_READ, 8'h00, 8'(TextBytes - 1)));
    push_cmd(make_cmd(ACT_READ, 8'h00, 8'h00));
  endtask

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    int unsigned run;
    int unsigned gap;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned fills;
    bit          held;
    bit          paused;
    fills  = 0;
    held   = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every edit on an empty line, both byte extremes, word kill over spaces
    push_cmd(make_cmd(ACT_READ, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_DEL_BACK, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_DEL_FWD, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_LEFT, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_RIGHT, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_KILL_START, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_KILL_WORD, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_KILL_END, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_INSERT, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_INSERT, 8'hff, 8'hff));
    push_cmd(make_cmd(ACT_INSERT, "a", 8'h00));
    push_cmd(make_cmd(ACT_INSERT, SPACE_BYTE, 8'h00));
    push_cmd(make_cmd(ACT_INSERT, "b", 8'h00));
    push_cmd(make_cmd(ACT_INSERT, SPACE_BYTE, 8'h00));
    push_cmd(make_cmd(ACT_READ, 8'h00, 8'h01));
    push_cmd(make_cmd(ACT_READ, 8'h00, 8'(TextBytes - 1)));
    push_cmd(make_cmd(ACT_LEFT, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_KILL_WORD, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_HOME, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_DEL_FWD, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_END, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_DEL_BACK, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_UNUSED_LO, 8'hff, 8'hff));
    push_cmd(make_cmd(ACT_UNUSED_HI, 8'h00, 8'h00));
    push_cmd(make_cmd(ACT_CLEAR, 8'h00, 8'h00));

    // random editing sessions, two of them filling the line to the brim
    while (sent_count < TotalItems) begin
      if ((fills == 0 && sent_count >= 300) || (fills == 1 && sent_count >= 750)) begin
        fill_line();
        fills++;
      end else begin
        edit_burst($urandom_range(20, 60));
      end
      // long receiver hold-off while commands keep coming, so the input stalls
      if (!held && sent_count >= 150) begin
        hold_off_req = 1'b1;
        held         = 1'b1;
      end
      // one full pause with nothing in flight
      if (!paused && sent_count >= 550) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    // catch any stray result after the last expected one
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("cursor_line_edit_buffer_core: match");
    end else begin
      $display("cursor_line_edit_buffer_core: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(LimitNs);
    $display("cursor_line_edit_buffer_core: mismatch");
    $finish;
  end

endmodule
